/* hw/rtl/bsfr_pkg.sv */
// Shared types and constants for the byte-stuffed frame receiver.
// Used by bsfr_core and byte_stuffed_frame_receiver; depends on nothing.

package bsfr_pkg;

    localparam int unsigned FRAME_CAPACITY = 128;
    localparam logic [7:0] IDLE_LIMIT_RESET = 8'd3;

    // Line codes
    localparam logic [7:0] DELIM          = 8'h2F;
    localparam logic [7:0] ESCAPE_BYTE    = 8'h3C;
    localparam logic [7:0] ESC_FOR_DELIM  = 8'h3D;
    localparam logic [7:0] ESC_FOR_ESCAPE = 8'h3E;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        MODE_HUNT = 2'd0,
        MODE_MSG  = 2'd1,
        MODE_ESC  = 2'd2
    } t_rx_mode;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    typedef struct packed {
        t_command   command;
        logic [7:0] rx_byte;
        logic       line_idle;
    } t_item;

    typedef struct packed {
        t_kind      result_kind;
        logic [7:0] decoded_byte;
        logic [7:0] byte_count;
        logic       frame_overflow;
    } t_result;

endpackage

/* hw/rtl/bsfr_core.sv */
// Deframer state and per-item decode: mode, length, overflow and idle count.
// Depends on bsfr_pkg for item/result structs, mode enum and line codes.

module bsfr_core #(
    parameter int unsigned P_FRAME_CAPACITY = bsfr_pkg::FRAME_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,        // consume i_item this cycle
    input  bsfr_pkg::t_item   i_item,
    input  logic [7:0]        i_idle_limit,
    output logic              o_has_result,  // i_item yields a result
    output bsfr_pkg::t_result o_result
);

    localparam logic [7:0] CAP = 8'(P_FRAME_CAPACITY);

    bsfr_pkg::t_rx_mode r_mode, n_mode;
    logic [7:0] r_count, n_count;
    logic       r_ovf, n_ovf;
    logic [7:0] r_idle, n_idle;

    logic [7:0] idle_inc;
    logic [7:0] limit_eff;
    logic [7:0] add_count;
    logic       add_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= bsfr_pkg::MODE_HUNT;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_idle  <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_idle  <= n_idle;
        end
    end

    always_comb begin
        idle_inc  = r_idle + 8'((r_idle != 8'hFF) ? 1 : 0);
        limit_eff = (i_idle_limit == 8'd0) ? 8'd1 : i_idle_limit;
        // saturating length for one more payload byte
        add_count = (r_count >= CAP) ? CAP : r_count + 8'd1;
        add_ovf   = (r_count >= CAP) ? 1'b1 : r_ovf;

        n_mode   = r_mode;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_idle   = r_idle;
        o_has_result = 1'b0;
        o_result.result_kind    = bsfr_pkg::KIND_DATA;
        o_result.decoded_byte   = '0;
        o_result.byte_count     = r_count;
        o_result.frame_overflow = r_ovf;

        if (i_item.command == bsfr_pkg::CMD_TICK) begin
            if (i_item.line_idle && r_mode == bsfr_pkg::MODE_MSG) begin
                if (idle_inc >= limit_eff) begin
                    // timeout: abandon partial frame
                    n_idle  = '0;
                    n_mode  = bsfr_pkg::MODE_HUNT;
                    n_count = '0;
                    n_ovf   = 1'b0;
                    o_has_result         = 1'b1;
                    o_result.result_kind = bsfr_pkg::KIND_ABORT;
                end else begin
                    n_idle = idle_inc;
                end
            end
        end else begin
            case (r_mode)
                bsfr_pkg::MODE_MSG: begin
                    if (i_item.rx_byte == bsfr_pkg::DELIM) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        o_has_result         = 1'b1;
                        o_result.result_kind = bsfr_pkg::KIND_END;
                    end else if (i_item.rx_byte == bsfr_pkg::ESCAPE_BYTE) begin
                        n_mode = bsfr_pkg::MODE_ESC;
                    end else begin
                        n_count = add_count;
                        n_ovf   = add_ovf;
                        o_has_result            = 1'b1;
                        o_result.decoded_byte   = i_item.rx_byte;
                        o_result.byte_count     = add_count;
                        o_result.frame_overflow = add_ovf;
                    end
                end
                bsfr_pkg::MODE_ESC: begin
                    n_mode = bsfr_pkg::MODE_MSG;
                    if (i_item.rx_byte == bsfr_pkg::ESC_FOR_DELIM ||
                        i_item.rx_byte == bsfr_pkg::ESC_FOR_ESCAPE) begin
                        n_count = add_count;
                        n_ovf   = add_ovf;
                        o_has_result            = 1'b1;
                        o_result.decoded_byte   =
                            (i_item.rx_byte == bsfr_pkg::ESC_FOR_DELIM) ?
                            bsfr_pkg::DELIM : bsfr_pkg::ESCAPE_BYTE;
                        o_result.byte_count     = add_count;
                        o_result.frame_overflow = add_ovf;
                    end
                end
                default: begin
                    // hunting: wait for a delimiter
                    if (i_item.rx_byte == bsfr_pkg::DELIM) begin
                        n_mode  = bsfr_pkg::MODE_MSG;
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_mode = bsfr_pkg::MODE_HUNT;
                    end
                end
            endcase
        end
    end

endmodule

/* hw/rtl/byte_stuffed_frame_receiver.sv */
// Top level of the byte-stuffed frame receiver: input register, output register,
// idle limit register and the bsfr_core decode stage. Depends on bsfr_pkg, bsfr_core.
//
// Channel   Direction  tdata (low bit up)                         tuser
// s_axis    in         rx_byte[7:0], line_idle[8], zero [15:9]    command (0 byte, 1 tick)
// m_axis    out        decoded_byte[7:0], byte_count[15:8],       result_kind
//                      frame_overflow[16], zero [23:17]
// cfg       in         i_cfg_wdata = idle_tick_limit, written when i_cfg_we is high
//
// One transfer per cycle in and out unless m_axis stalls; a result passes the input
// register, then the result register, on its way to m_axis. The decode state advances
// only when the held item can move on: items without a result always move, items with
// a result wait for a free result register, so an m_axis stall reaches s_axis_tready
// combinationally. Synchronous active-low reset returns the receiver to hunting with
// a limit of three ticks and empties both registers.

module byte_stuffed_frame_receiver #(
    parameter int unsigned P_FRAME_CAPACITY = bsfr_pkg::FRAME_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,    // idle_tick_limit
    // received bytes and ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], line_idle[8], pad
    input  logic        s_axis_tuser,   // command
    // decoded results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // decoded_byte, byte_count, frame_overflow, pad
    output logic [1:0]  m_axis_tuser    // result_kind
);

    localparam logic [7:0] CAP = 8'(P_FRAME_CAPACITY);

    logic [7:0]        r_idle_limit;
    logic              r_in_valid;
    bsfr_pkg::t_item   r_in;
    logic              r_out_valid;
    bsfr_pkg::t_result r_out;

    logic              has_result;
    bsfr_pkg::t_result result;
    logic              out_free;
    logic              step;

    // Result register is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || m_axis_tready;
    // Advance the held item: results need room, others drop straight through.
    assign step = r_in_valid && (!has_result || out_free);
    assign s_axis_tready = !r_in_valid || step;

    // Idle tick limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= bsfr_pkg::IDLE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_idle_limit <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.command   <= bsfr_pkg::t_command'(s_axis_tuser);
            r_in.rx_byte   <= s_axis_tdata[7:0];
            r_in.line_idle <= s_axis_tdata[8];
        end
    end

    bsfr_core #(
        .P_FRAME_CAPACITY (P_FRAME_CAPACITY)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_item       (r_in),
        .i_idle_limit (r_idle_limit),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // Result register: load on a producing step, drop on a downstream transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && has_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && has_result) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.result_kind;
    assign m_axis_tdata  = {7'd0, r_out.frame_overflow, r_out.byte_count,
                            r_out.decoded_byte};

    // Length never passes capacity.
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.byte_count <= CAP)
        else $error("frame length beyond capacity");

    // Overflow only once the length has saturated.
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_overflow) |-> r_out.byte_count == CAP)
        else $error("overflow without saturated length");

    // A data result always counts at least itself.
    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.result_kind == bsfr_pkg::KIND_DATA)
        |-> r_out.byte_count != 8'd0)
        else $error("data result with zero length");

    // A result is never overwritten while stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(step && has_result))
        else $error("result register overwritten");

endmodule

/* sim/byte_stuffed_frame_receiver_tb.sv */
// Self-checking testbench for the byte-stuffed frame receiver: random and directed
// byte/tick streams, a deframing predictor with a result scoreboard, random stalls.
// Depends on bsfr_pkg and byte_stuffed_frame_receiver.
`timescale 1ns / 1ps

module byte_stuffed_frame_receiver_tb;

    localparam int HOLD_CYCLES = 64;      // long receiver hold-off used to back the block up
    localparam int DRAIN_CYCLES = 4;      // two-stage pipeline plus margin
    localparam int PHASE_ITEMS = 40;

    // Deframing predictor plus the queue of results it still waits for.
    class deframe_scoreboard;
        bsfr_pkg::t_rx_mode mode;
        logic [7:0]         payload_len;
        logic               overflowed;
        logic [7:0]         idle_count;
        logic [7:0]         tick_limit;
        bsfr_pkg::t_result  pending_results[$];
        int                 mismatches;

        function new();
            mode        = bsfr_pkg::MODE_HUNT;
            payload_len = '0;
            overflowed  = 1'b0;
            idle_count  = '0;
            tick_limit  = bsfr_pkg::IDLE_LIMIT_RESET;
            mismatches  = 0;
        endfunction

        function void set_limit(logic [7:0] lim);
            tick_limit = lim;
        endfunction

        function bsfr_pkg::t_result frame_summary(bsfr_pkg::t_kind kind, logic [7:0] data);
            bsfr_pkg::t_result res;
            res.result_kind    = kind;
            res.decoded_byte   = data;
            res.byte_count     = payload_len;
            res.frame_overflow = overflowed;
            return res;
        endfunction

        function void count_payload();
            if (payload_len >= 8'(bsfr_pkg::FRAME_CAPACITY)) begin
                payload_len = 8'(bsfr_pkg::FRAME_CAPACITY);
                overflowed  = 1'b1;
            end else begin
                payload_len = payload_len + 8'd1;
            end
        endfunction

        // Advance the decode state by one item; return 1 with res filled when a result is due.
        function bit deframe(bsfr_pkg::t_item it, output bsfr_pkg::t_result res);
            logic [7:0] eff_limit;
            res = '0;
            if (it.command == bsfr_pkg::CMD_TICK) begin
                if (!it.line_idle || mode != bsfr_pkg::MODE_MSG)
                    return 1'b0;
                if (idle_count != 8'hFF)
                    idle_count = idle_count + 8'd1;
                eff_limit = (tick_limit == 8'd0) ? 8'd1 : tick_limit;
                if (idle_count >= eff_limit) begin
                    idle_count  = '0;
                    mode        = bsfr_pkg::MODE_HUNT;
                    res         = frame_summary(bsfr_pkg::KIND_ABORT, 8'd0);
                    payload_len = '0;
                    overflowed  = 1'b0;
                    return 1'b1;
                end
                return 1'b0;
            end
            case (mode)
                bsfr_pkg::MODE_MSG: begin
                    if (it.rx_byte == bsfr_pkg::DELIM) begin
                        res         = frame_summary(bsfr_pkg::KIND_END, 8'd0);
                        payload_len = '0;
                        overflowed  = 1'b0;
                        return 1'b1;
                    end
                    if (it.rx_byte == bsfr_pkg::ESCAPE_BYTE) begin
                        mode = bsfr_pkg::MODE_ESC;
                        return 1'b0;
                    end
                    count_payload();
                    res = frame_summary(bsfr_pkg::KIND_DATA, it.rx_byte);
                    return 1'b1;
                end
                bsfr_pkg::MODE_ESC: begin
                    mode = bsfr_pkg::MODE_MSG;
                    if (it.rx_byte == bsfr_pkg::ESC_FOR_DELIM ||
                        it.rx_byte == bsfr_pkg::ESC_FOR_ESCAPE) begin
                        count_payload();
                        res = frame_summary(bsfr_pkg::KIND_DATA,
                            (it.rx_byte == bsfr_pkg::ESC_FOR_DELIM) ?
                            bsfr_pkg::DELIM : bsfr_pkg::ESCAPE_BYTE);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                default: begin
                    if (it.rx_byte == bsfr_pkg::DELIM) begin
                        payload_len = '0;
                        overflowed  = 1'b0;
                        mode        = bsfr_pkg::MODE_MSG;
                    end else begin
                        mode = bsfr_pkg::MODE_HUNT;
                    end
                    return 1'b0;
                end
            endcase
        endfunction

        function void note_item(bsfr_pkg::t_item it);
            bsfr_pkg::t_result res;
            if (deframe(it, res))
                pending_results.push_back(res);
        endfunction

        function void report(string what, bsfr_pkg::t_result want, bsfr_pkg::t_result got);
            mismatches++;
            if (mismatches <= 10)
                $display({"[%0t] %s: expected kind %0d byte %02h len %0d ovf %0b,",
                          " got kind %0d byte %02h len %0d ovf %0b"},
                         $realtime, what, want.result_kind, want.decoded_byte,
                         want.byte_count, want.frame_overflow, got.result_kind,
                         got.decoded_byte, got.byte_count, got.frame_overflow);
        endfunction

        function void check_result(bsfr_pkg::t_result got);
            bsfr_pkg::t_result want;
            if (pending_results.size() == 0) begin
                report("result with nothing pending", 'x, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.result_kind != want.result_kind || got.decoded_byte != want.decoded_byte ||
                got.byte_count != want.byte_count ||
                got.frame_overflow != want.frame_overflow)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // rx_byte[7:0], line_idle[8], zero pad
    logic        s_axis_tuser;     // command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // decoded_byte[7:0], byte_count[15:8], frame_overflow[16], pad
    logic [1:0]  m_axis_tuser;     // result_kind

    deframe_scoreboard sb = new();

    bit         steady;            // when set, neither side inserts random gaps
    bit         hold_request;      // ask the result sink for one long hold-off
    int         items_sent;
    logic [7:0] cur_limit;

    byte_stuffed_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length in cycles: mostly none, sometimes short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result sink: random stalls, plus the long hold-off on request, counted here.
    initial begin : result_sink
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (steady) begin
                m_axis_tready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                m_axis_tready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        bsfr_pkg::t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.result_kind    = bsfr_pkg::t_kind'(m_axis_tuser);
            got.decoded_byte   = m_axis_tdata[7:0];
            got.byte_count     = m_axis_tdata[15:8];
            got.frame_overflow = m_axis_tdata[16];
            sb.check_result(got);
        end
    end

    // Offer one item, with an optional gap in front; call and return at a falling edge.
    task automatic send_item(bsfr_pkg::t_command cmd, logic [7:0] data, logic idle);
        int              gap;
        bsfr_pkg::t_item it;
        it.command   = cmd;
        it.rx_byte   = data;
        it.line_idle = idle;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, idle, data};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] data);
        send_item(bsfr_pkg::CMD_BYTE, data, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_tick(logic idle);
        send_item(bsfr_pkg::CMD_TICK, 8'($urandom_range(0, 255)), idle);
    endtask

    // Stop offering, wait for every predicted result, then let the pipeline settle.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_idle_limit(logic [7:0] lim);
        drain_pipeline();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lim;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_limit(lim);
        cur_limit = lim;
    endtask

    // One frame: opening delimiter, payload with escapes, then a closing
    // delimiter or idle ticks until the frame is abandoned. Noisy frames
    // also carry stray ticks and broken escapes.
    task automatic send_frame(int len, bit noisy, bit abandon);
        logic [7:0] b;
        int         r;
        send_byte(bsfr_pkg::DELIM);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (noisy && r < 8) begin
                send_tick($urandom_range(0, 3) == 0);
            end else if (noisy && r < 12) begin
                send_byte(bsfr_pkg::ESCAPE_BYTE);
                do b = 8'($urandom_range(0, 255));
                while (b == bsfr_pkg::ESC_FOR_DELIM || b == bsfr_pkg::ESC_FOR_ESCAPE);
                if ($urandom_range(0, 2) == 0)
                    b = ($urandom_range(0, 1) != 0) ? bsfr_pkg::DELIM : bsfr_pkg::ESCAPE_BYTE;
                send_byte(b);
            end else begin
                b = 8'($urandom_range(0, 255));
                if (r >= 80)
                    b = ($urandom_range(0, 1) != 0) ? bsfr_pkg::DELIM : bsfr_pkg::ESCAPE_BYTE;
                if (b == bsfr_pkg::DELIM || b == bsfr_pkg::ESCAPE_BYTE) begin
                    send_byte(bsfr_pkg::ESCAPE_BYTE);
                    send_byte((b == bsfr_pkg::DELIM) ?
                              bsfr_pkg::ESC_FOR_DELIM : bsfr_pkg::ESC_FOR_ESCAPE);
                end else begin
                    send_byte(b);
                end
            end
        end
        if (abandon)
            repeat ((cur_limit == 8'd0) ? 1 : int'(cur_limit)) send_tick(1'b1);
        else
            send_byte(bsfr_pkg::DELIM);
    endtask

    task automatic run_random_phase(logic [7:0] lim);
        int  target;
        int  len;
        bit  abandon;
        write_idle_limit(lim);
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) begin
            // stray line noise between frames
            repeat ($urandom_range(0, 2)) begin
                if ($urandom_range(0, 1) != 0)
                    send_byte(8'($urandom_range(0, 255)));
                else
                    send_tick(1'($urandom_range(0, 1)));
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            abandon = (cur_limit <= 8'd8) && ($urandom_range(0, 5) == 0);
            send_frame(len, 1'b1, abandon);
        end
    endtask

    task automatic run_directed();
        send_byte(8'h41);                     // hunting: ignore non-delimiter
        send_tick(1'b1);                      // hunting: tick does nothing
        send_byte(bsfr_pkg::DELIM);           // enter message mode
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(bsfr_pkg::ESCAPE_BYTE);
        send_byte(bsfr_pkg::ESC_FOR_DELIM);   // decodes to delimiter
        send_byte(bsfr_pkg::ESCAPE_BYTE);
        send_byte(bsfr_pkg::ESC_FOR_ESCAPE);  // decodes to escape
        send_byte(bsfr_pkg::ESCAPE_BYTE);
        send_byte(bsfr_pkg::DELIM);           // delimiter after escape: drop
        send_byte(bsfr_pkg::ESCAPE_BYTE);
        send_byte(bsfr_pkg::ESCAPE_BYTE);     // escape after escape: drop
        send_tick(1'b0);                      // busy line: not counted
        send_byte(bsfr_pkg::ESCAPE_BYTE);
        send_tick(1'b1);                      // tick after escape: not counted
        send_byte(bsfr_pkg::ESC_FOR_DELIM);
        send_byte(bsfr_pkg::DELIM);           // frame end, length five
        send_byte(bsfr_pkg::DELIM);           // empty frame
        send_byte(8'h80);
        repeat (3) send_tick(1'b1);           // reset limit of three: abort
        send_tick(1'b1);                      // back to hunting: ignored
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'd0;
        s_axis_tuser  = 1'b0;
        steady        = 1'b0;
        hold_request  = 1'b0;
        items_sent    = 0;
        cur_limit     = bsfr_pkg::IDLE_LIMIT_RESET;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        run_random_phase(8'd1);

        // widest limit; push one clean frame well past capacity to force overflow
        run_random_phase(8'd255);
        send_frame(140, 1'b0, 1'b0);
        send_frame(2, 1'b0, 1'b0);

        // zero limit behaves as one; run this phase with no gaps on either side
        steady = 1'b1;
        run_random_phase(8'd0);
        steady = 1'b0;

        run_random_phase(8'($urandom_range(2, 254)));

        // hold the result side off while a long frame keeps coming, so the block backs up
        write_idle_limit(8'd3);
        steady       = 1'b1;
        hold_request = 1'b1;
        send_frame(40, 1'b0, 1'b0);
        steady       = 1'b0;
        run_random_phase(8'd3);

        run_random_phase(8'($urandom_range(1, 255)));

        drain_pipeline();
        repeat (10) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("byte_stuffed_frame_receiver regression: pass");
        else
            $display("byte_stuffed_frame_receiver regression: fail");
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("byte_stuffed_frame_receiver regression: fail");
        $finish;
    end

endmodule
